[hdl/dbchs_pkg.sv]
package dbchs_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_AT_END   = 2'd1,
    STATUS_PAST_END = 2'd2,
    STATUS_NO_DRIVE = 2'd3
  } status_e;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_STROBE_EARLY = 2'd0;
  localparam logic [1:0] REG_STROBE_LATE  = 2'd1;
  localparam logic [1:0] REG_OFFSET_PLUS  = 2'd2;
  localparam logic [1:0] REG_OFFSET_MINUS = 2'd3;

  localparam int ROM_TYPES    = 4;
  localparam int ROM_PARTS    = 8;
  localparam int RETRY_LEVELS = 20;

  // Recovery code bits
  localparam logic [3:0] RECOV_EARLY = 4'b0001;
  localparam logic [3:0] RECOV_LATE  = 4'b0010;
  localparam logic [3:0] RECOV_PLUS  = 4'b0100;
  localparam logic [3:0] RECOV_MINUS = 4'b1000;

  localparam logic [3:0] RECOV_TABLE [RETRY_LEVELS] = '{
    4'b0000, 4'b0000, 4'b0000, RECOV_EARLY,
    RECOV_EARLY, RECOV_LATE, RECOV_LATE, RECOV_PLUS | RECOV_LATE,
    RECOV_PLUS | RECOV_LATE, RECOV_PLUS, RECOV_PLUS, RECOV_PLUS | RECOV_EARLY,
    RECOV_PLUS | RECOV_EARLY, RECOV_MINUS | RECOV_EARLY, RECOV_MINUS | RECOV_EARLY,
    RECOV_PLUS,
    RECOV_PLUS, RECOV_PLUS | RECOV_LATE, RECOV_PLUS | RECOV_LATE, 4'b0000
  };

  // Partition sizes in blocks
  localparam logic [18:0] PART_BLOCKS [ROM_TYPES][ROM_PARTS] = '{
    '{19'd18240, 19'd12160, 19'd232256, 19'd232256,
      19'd154432, 19'd154432, 19'd154432, 19'd495520},
    '{19'd18392, 19'd12122, 19'd231990, 19'd78166,
      19'd0, 19'd0, 19'd0, 19'd340670},
    '{19'd18400, 19'd12320, 19'd99840, 19'd0,
      19'd0, 19'd0, 19'd0, 19'd130300},
    '{19'd18260, 19'd12210, 19'd59180, 19'd0,
      19'd0, 19'd0, 19'd0, 19'd89650}
  };

  // First cylinder of each partition
  localparam logic [9:0] PART_CYL0 [ROM_TYPES][ROM_PARTS] = '{
    '{10'd0, 10'd30, 10'd50, 10'd432, 10'd50, 10'd304, 10'd558, 10'd0},
    '{10'd0, 10'd43, 10'd73, 10'd443, 10'd0, 10'd0, 10'd0, 10'd0},
    '{10'd0, 10'd115, 10'd191, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
    '{10'd0, 10'd166, 10'd277, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0}
  };

  // Sectors per cylinder (spt * tpc)
  localparam logic [9:0] PER_CYL [ROM_TYPES] = '{10'd608, 10'd418, 10'd160, 10'd110};

  // ceil(2^29 / per_cyl): exact quotient for any block below 2^19
  localparam int          CYL_SHIFT = 29;
  localparam logic [22:0] CYL_RECIP [ROM_TYPES] =
    '{23'd883012, 23'd1284381, 23'd3355444, 23'd4880645};

  // 1: 32 sectors per track, 0: 22 sectors per track
  localparam logic SPT_IS_32 [ROM_TYPES] = '{1'b1, 1'b0, 1'b1, 1'b0};

  // ceil(2^16 / 22): exact for remainders below 2^15
  localparam int          SPT22_SHIFT = 16;
  localparam logic [11:0] SPT22_RECIP = 12'd2979;
  localparam logic [4:0]  SPT22       = 5'd22;

  // Per-request fields carried along the pipeline
  typedef struct packed {
    status_e     status;
    logic [1:0]  dt;
    logic [9:0]  cyl0;
    logic [15:0] rmask;
    logic [15:0] wc;
  } meta_t;

endpackage

[hdl/disk_block_to_chs_translator_top.sv]
// Disk block to cylinder/track/sector translator. Each request transaction
// (drive type, partition, block number, byte count, retry count) yields one
// result transaction: a status, the cylinder word (cylinder plus partition
// offset, ORed with the recovery bits chosen by the retry count through the
// four APB mask registers), track, sector and the negated word count. Fields
// other than status read zero unless status is OK. The block is a six-stage
// pipeline: it takes one request every cycle while in_stall_o is low. Its
// depth is set by the two constant-reciprocal multipliers and the
// back-multiplies that split the block number into cylinder, track and
// sector. out_stall_i backpressures stage by stage, so empty stages keep
// filling while a finished result waits. The user must write the mask
// registers only while no transaction is in flight; the block itself does
// not enforce it.
module disk_block_to_chs_translator_top #(
  parameter int DRIVE_TYPES = 4,
  parameter int PARTITIONS  = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         drive_type_i,
  input  logic [2:0]         partition_i,
  input  logic [23:0]        block_number_i,
  input  logic [15:0]        byte_count_i,
  input  logic [4:0]         retry_count_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [15:0]        cylinder_word_o,
  output logic [7:0]         track_o,
  output logic [7:0]         sector_o,
  output logic signed [15:0] word_count_o
);

  // ---------------------------------------------------------------------------
  // Mask registers
  // ---------------------------------------------------------------------------
  logic [15:0] early_mask_q, late_mask_q, plus_mask_q, minus_mask_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      early_mask_q <= '0;
      late_mask_q  <= '0;
      plus_mask_q  <= '0;
      minus_mask_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        dbchs_pkg::REG_STROBE_EARLY: early_mask_q <= pwdata[15:0];
        dbchs_pkg::REG_STROBE_LATE:  late_mask_q  <= pwdata[15:0];
        dbchs_pkg::REG_OFFSET_PLUS:  plus_mask_q  <= pwdata[15:0];
        dbchs_pkg::REG_OFFSET_MINUS: minus_mask_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      dbchs_pkg::REG_STROBE_EARLY: prdata = {16'd0, early_mask_q};
      dbchs_pkg::REG_STROBE_LATE:  prdata = {16'd0, late_mask_q};
      dbchs_pkg::REG_OFFSET_PLUS:  prdata = {16'd0, plus_mask_q};
      dbchs_pkg::REG_OFFSET_MINUS: prdata = {16'd0, minus_mask_q};
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its successor
  // moves on. Only a full pipeline with a stalled output stalls the input.
  // ---------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, out_v_q;
  logic en1, en2, en3, en4, en5, en_out;

  assign en_out     = !out_v_q || !out_stall_i;
  assign en5        = !s5_v_q || en_out;
  assign en4        = !s4_v_q || en5;
  assign en3        = !s3_v_q || en4;
  assign en2        = !s2_v_q || en3;
  assign en1        = !s1_v_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1)    s1_v_q  <= in_valid_i;
      if (en2)    s2_v_q  <= s1_v_q;
      if (en3)    s3_v_q  <= s2_v_q;
      if (en4)    s4_v_q  <= s3_v_q;
      if (en5)    s5_v_q  <= s4_v_q;
      if (en_out) out_v_q <= s5_v_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: ROM lookup, range check, recovery mask, word count
  // ---------------------------------------------------------------------------
  logic             dt_ok, pt_ok;
  logic [1:0]       dt;
  logic [18:0]      part_size;
  logic [7:0]       nblk;
  logic [24:0]      end_sum;
  logic [3:0]       rcode;
  dbchs_pkg::meta_t s1_d;

  always_comb begin
    dt_ok     = (int'(drive_type_i) < DRIVE_TYPES) &&
                (int'(drive_type_i) < dbchs_pkg::ROM_TYPES);
    pt_ok     = int'(partition_i) < PARTITIONS;
    dt        = drive_type_i[1:0];
    part_size = pt_ok ? dbchs_pkg::PART_BLOCKS[dt][partition_i] : '0;
    // blocks touched, rounded up
    nblk      = 8'((17'(byte_count_i) + 17'd511) >> 9);
    end_sum   = 25'(block_number_i) + 25'(nblk);
    rcode     = (int'(retry_count_i) < dbchs_pkg::RETRY_LEVELS) ?
                dbchs_pkg::RECOV_TABLE[retry_count_i] : 4'b0000;

    s1_d.dt    = dt;
    s1_d.cyl0  = pt_ok ? dbchs_pkg::PART_CYL0[dt][partition_i] : '0;
    s1_d.rmask = ((rcode & dbchs_pkg::RECOV_EARLY) != '0 ? early_mask_q : '0) |
                 ((rcode & dbchs_pkg::RECOV_LATE)  != '0 ? late_mask_q  : '0) |
                 ((rcode & dbchs_pkg::RECOV_PLUS)  != '0 ? plus_mask_q  : '0) |
                 ((rcode & dbchs_pkg::RECOV_MINUS) != '0 ? minus_mask_q : '0);
    s1_d.wc    = 16'd0 - 16'(byte_count_i >> 1);

    if (!dt_ok) begin
      s1_d.status = dbchs_pkg::STATUS_NO_DRIVE;
    end else if (block_number_i == 24'(part_size)) begin
      s1_d.status = dbchs_pkg::STATUS_AT_END;
    end else if (end_sum > 25'(part_size)) begin
      s1_d.status = dbchs_pkg::STATUS_PAST_END;
    end else begin
      s1_d.status = dbchs_pkg::STATUS_OK;
    end
  end

  // an OK block lies below the largest partition, so 19 bits carry it
  dbchs_pkg::meta_t s1_meta_q, s2_meta_q, s3_meta_q, s4_meta_q, s5_meta_q;
  logic [18:0]      s1_bn_q, s2_bn_q, s3_bn_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_meta_q <= s1_d;
      s1_bn_q   <= block_number_i[18:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: cylinder = block * ceil(2^29 / per_cyl) >> 29
  // ---------------------------------------------------------------------------
  logic [41:0] cyl_prod;
  logic [9:0]  s2_cyl_q;

  assign cyl_prod = 42'(s1_bn_q) * 42'(dbchs_pkg::CYL_RECIP[s1_meta_q.dt]);

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_meta_q <= s1_meta_q;
      s2_bn_q   <= s1_bn_q;
      s2_cyl_q  <= cyl_prod[dbchs_pkg::CYL_SHIFT +: 10];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: back-multiply cylinder * per_cyl
  // ---------------------------------------------------------------------------
  logic [19:0] back_prod;
  logic [9:0]  s3_cyl_q;
  logic [18:0] s3_back_q;

  assign back_prod = 20'(s2_cyl_q) * 20'(dbchs_pkg::PER_CYL[s2_meta_q.dt]);

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_meta_q <= s2_meta_q;
      s3_bn_q   <= s2_bn_q;
      s3_cyl_q  <= s2_cyl_q;
      s3_back_q <= back_prod[18:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: remainder within the cylinder, cylinder word with offset
  // ---------------------------------------------------------------------------
  logic [18:0] rem_full;
  logic [9:0]  s4_rem_q;
  logic [15:0] s4_cylw_q;

  assign rem_full = s3_bn_q - s3_back_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_meta_q <= s3_meta_q;
      s4_rem_q  <= rem_full[9:0];
      s4_cylw_q <= (16'(s3_cyl_q) + 16'(s3_meta_q.cyl0)) | s3_meta_q.rmask;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: track = remainder / sectors per track
  // ---------------------------------------------------------------------------
  logic [21:0] trk_prod;
  logic [4:0]  trk_d;
  logic [4:0]  s5_trk_q;
  logic [9:0]  s5_rem_q;
  logic [15:0] s5_cylw_q;

  assign trk_prod = 22'(s4_rem_q) * 22'(dbchs_pkg::SPT22_RECIP);
  assign trk_d    = dbchs_pkg::SPT_IS_32[s4_meta_q.dt] ? s4_rem_q[9:5] :
                    trk_prod[dbchs_pkg::SPT22_SHIFT +: 5];

  always_ff @(posedge clk_i) begin
    if (en5) begin
      s5_meta_q <= s4_meta_q;
      s5_rem_q  <= s4_rem_q;
      s5_cylw_q <= s4_cylw_q;
      s5_trk_q  <= trk_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: sector, zeroing of non-OK results, output register
  // ---------------------------------------------------------------------------
  logic [9:0]  trk_x22;
  logic [9:0]  sec_wide;
  logic [4:0]  sec_d;
  logic        res_ok;
  logic [1:0]  out_status_q;
  logic [15:0] out_cylw_q, out_wc_q;
  logic [7:0]  out_trk_q, out_sec_q;

  assign trk_x22  = 10'(s5_trk_q) * 10'(dbchs_pkg::SPT22);
  assign sec_wide = s5_rem_q - trk_x22;
  assign sec_d    = dbchs_pkg::SPT_IS_32[s5_meta_q.dt] ? s5_rem_q[4:0] : sec_wide[4:0];
  assign res_ok   = s5_meta_q.status == dbchs_pkg::STATUS_OK;

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      out_status_q <= s5_meta_q.status;
      out_cylw_q   <= res_ok ? s5_cylw_q : '0;
      out_trk_q    <= res_ok ? 8'(s5_trk_q) : '0;
      out_sec_q    <= res_ok ? 8'(sec_d) : '0;
      out_wc_q     <= res_ok ? s5_meta_q.wc : '0;
    end
  end

  assign out_valid_o     = out_v_q;
  assign status_o        = out_status_q;
  assign cylinder_word_o = out_cylw_q;
  assign track_o         = out_trk_q;
  assign sector_o        = out_sec_q;
  assign word_count_o    = $signed(out_wc_q);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fail_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != dbchs_pkg::STATUS_OK) |->
      (cylinder_word_o == '0 && track_o == '0 && sector_o == '0 && word_count_o == '0))
    else $error("non-OK result carries nonzero fields");

  a_ok_geometry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == dbchs_pkg::STATUS_OK) |->
      (sector_o < 8'd32 && track_o < 8'd19))
    else $error("track or sector outside drive geometry");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && s1_v_q && s5_v_q))
    else $error("input stalled with room in the pipeline");

  a_ok_cyl_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && s2_meta_q.status == dbchs_pkg::STATUS_OK) |-> (s2_cyl_q < 10'd816))
    else $error("cylinder quotient out of range");

endmodule

[sim/disk_block_to_chs_translator_chk.sv]
`timescale 1ns / 100ps

// Watches the APB, request and result ports of the translator, keeps a shadow copy
// of the recovery masks, predicts each result and checks it against the block.
module disk_block_to_chs_translator_chk #(
  parameter int DRIVE_TYPES = 4,
  parameter int PARTITIONS  = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         drive_type_i,
  input  logic [2:0]         partition_i,
  input  logic [23:0]        block_number_i,
  input  logic [15:0]        byte_count_i,
  input  logic [4:0]         retry_count_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         status_i,
  input  logic [15:0]        cylinder_word_i,
  input  logic [7:0]         track_i,
  input  logic [7:0]         sector_i,
  input  logic signed [15:0] word_count_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    dbchs_pkg::status_e status;
    logic [15:0]        cyl_word;
    logic [7:0]         track;
    logic [7:0]         sector;
    logic signed [15:0] word_count;
  } chs_result_t;

  // Drive geometry: blocks and first cylinder per partition
  localparam int unsigned PART_SIZE [4][8] = '{
    '{18240, 12160, 232256, 232256, 154432, 154432, 154432, 495520},
    '{18392, 12122, 231990, 78166, 0, 0, 0, 340670},
    '{18400, 12320, 99840, 0, 0, 0, 0, 130300},
    '{18260, 12210, 59180, 0, 0, 0, 0, 89650}
  };
  localparam int unsigned PART_FIRST_CYL [4][8] = '{
    '{0, 30, 50, 432, 50, 304, 558, 0},
    '{0, 43, 73, 443, 0, 0, 0, 0},
    '{0, 115, 191, 0, 0, 0, 0, 0},
    '{0, 166, 277, 0, 0, 0, 0, 0}
  };
  localparam int unsigned SECTORS_PER_TRACK [4] = '{32, 22, 32, 22};
  localparam int unsigned TRACKS_PER_CYL [4]    = '{19, 19, 5, 5};

  // Recovery actions per retry attempt
  localparam logic [3:0] RETRY_RECOVERY [20] = '{
    4'b0000, 4'b0000, 4'b0000, dbchs_pkg::RECOV_EARLY,
    dbchs_pkg::RECOV_EARLY, dbchs_pkg::RECOV_LATE, dbchs_pkg::RECOV_LATE,
    dbchs_pkg::RECOV_PLUS | dbchs_pkg::RECOV_LATE,
    dbchs_pkg::RECOV_PLUS | dbchs_pkg::RECOV_LATE,
    dbchs_pkg::RECOV_PLUS, dbchs_pkg::RECOV_PLUS,
    dbchs_pkg::RECOV_PLUS | dbchs_pkg::RECOV_EARLY,
    dbchs_pkg::RECOV_PLUS | dbchs_pkg::RECOV_EARLY,
    dbchs_pkg::RECOV_MINUS | dbchs_pkg::RECOV_EARLY,
    dbchs_pkg::RECOV_MINUS | dbchs_pkg::RECOV_EARLY,
    dbchs_pkg::RECOV_PLUS,
    dbchs_pkg::RECOV_PLUS,
    dbchs_pkg::RECOV_PLUS | dbchs_pkg::RECOV_LATE,
    dbchs_pkg::RECOV_PLUS | dbchs_pkg::RECOV_LATE,
    4'b0000
  };

  logic [15:0] early_mask;
  logic [15:0] late_mask;
  logic [15:0] plus_mask;
  logic [15:0] minus_mask;

  chs_result_t expected_chs [$];
  chs_result_t want;

  function automatic chs_result_t translate_block(input logic [2:0]  dt,
                                                  input logic [2:0]  pt,
                                                  input logic [23:0] bn,
                                                  input logic [15:0] bc,
                                                  input logic [4:0]  rc);
    chs_result_t res;
    int unsigned size;
    int unsigned first_cyl;
    int unsigned spt;
    int unsigned per_cyl;
    int unsigned nblk;
    int unsigned cyl;
    int unsigned rem;
    logic [15:0] rmask;
    logic [3:0]  code;
    res = '0;
    res.status = dbchs_pkg::STATUS_OK;
    if (dt >= DRIVE_TYPES || dt >= dbchs_pkg::ROM_TYPES) begin
      res.status = dbchs_pkg::STATUS_NO_DRIVE;
      return res;
    end
    size = 0;
    first_cyl = 0;
    // absent partition behaves as zero blocks at cylinder 0
    if (pt < PARTITIONS) begin
      size = PART_SIZE[dt[1:0]][pt];
      first_cyl = PART_FIRST_CYL[dt[1:0]][pt];
    end
    nblk = (32'(bc) + 511) >> 9;
    if (32'(bn) == size) begin
      res.status = dbchs_pkg::STATUS_AT_END;
      return res;
    end
    if (32'(bn) + nblk > size) begin
      res.status = dbchs_pkg::STATUS_PAST_END;
      return res;
    end
    spt = SECTORS_PER_TRACK[dt[1:0]];
    per_cyl = spt * TRACKS_PER_CYL[dt[1:0]];
    cyl = 32'(bn) / per_cyl + first_cyl;
    rem = 32'(bn) % per_cyl;
    rmask = '0;
    if (rc < dbchs_pkg::RETRY_LEVELS) begin
      code = RETRY_RECOVERY[rc];
      if ((code & dbchs_pkg::RECOV_EARLY) != 0) rmask |= early_mask;
      if ((code & dbchs_pkg::RECOV_LATE) != 0)  rmask |= late_mask;
      if ((code & dbchs_pkg::RECOV_PLUS) != 0)  rmask |= plus_mask;
      if ((code & dbchs_pkg::RECOV_MINUS) != 0) rmask |= minus_mask;
    end
    res.cyl_word   = cyl[15:0] | rmask;
    res.track      = 8'(rem / spt);
    res.sector     = 8'(rem % spt);
    res.word_count = 16'(0 - 32'(bc >> 1));
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      early_mask = '0;
      late_mask = '0;
      plus_mask = '0;
      minus_mask = '0;
      expected_chs.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          dbchs_pkg::REG_STROBE_EARLY: early_mask = pwdata[15:0];
          dbchs_pkg::REG_STROBE_LATE:  late_mask = pwdata[15:0];
          dbchs_pkg::REG_OFFSET_PLUS:  plus_mask = pwdata[15:0];
          dbchs_pkg::REG_OFFSET_MINUS: minus_mask = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        expected_chs.push_back(translate_block(drive_type_i, partition_i, block_number_i,
                                               byte_count_i, retry_count_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_chs.size() == 0) begin
          fail_count_o++;
          $error("unexpected result transaction: status %0d cylinder_word %0h",
                 status_i, cylinder_word_i);
        end else begin
          want = expected_chs.pop_front();
          if (status_i !== want.status) begin
            fail_count_o++;
            $error("status: expected %0d, got %0d", want.status, status_i);
          end
          if (cylinder_word_i !== want.cyl_word) begin
            fail_count_o++;
            $error("cylinder_word: expected %0h, got %0h", want.cyl_word, cylinder_word_i);
          end
          if (track_i !== want.track) begin
            fail_count_o++;
            $error("track: expected %0d, got %0d", want.track, track_i);
          end
          if (sector_i !== want.sector) begin
            fail_count_o++;
            $error("sector: expected %0d, got %0d", want.sector, sector_i);
          end
          if (word_count_i !== want.word_count) begin
            fail_count_o++;
            $error("word_count: expected %0d, got %0d", want.word_count, word_count_i);
          end
        end
      end
      pending_o = expected_chs.size();
    end
  end

endmodule

[sim/disk_block_to_chs_translator_top_tb.sv]
`timescale 1ns / 100ps

// Stimulus and verdict for the block-to-CHS translator. The checker beside the
// DUT does all prediction and comparison; this module only drives ports.
module disk_block_to_chs_translator_top_tb;

  localparam int PHASES          = 6;     // random phases, one mask setting each
  localparam int ITEMS_PER_PHASE = 255;
  localparam int IDLE_LIMIT      = 1000;  // cycles with no transaction at all
  localparam int DRAIN_CYCLES    = 12;    // idle margin before the verdict

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         drive_type_i;
  logic [2:0]         partition_i;
  logic [23:0]        block_number_i;
  logic [15:0]        byte_count_i;
  logic [4:0]         retry_count_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         status_o;
  logic [15:0]        cylinder_word_o;
  logic [7:0]         track_o;
  logic [7:0]         sector_o;
  logic signed [15:0] word_count_o;

  int fail_count;
  int pending;
  int requests_sent;
  int results_taken;
  int mask_settings;
  int idle_cycles = 0;

  disk_block_to_chs_translator_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .drive_type_i    (drive_type_i),
    .partition_i     (partition_i),
    .block_number_i  (block_number_i),
    .byte_count_i    (byte_count_i),
    .retry_count_i   (retry_count_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .cylinder_word_o (cylinder_word_o),
    .track_o         (track_o),
    .sector_o        (sector_o),
    .word_count_o    (word_count_o)
  );

  disk_block_to_chs_translator_chk chs_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .drive_type_i    (drive_type_i),
    .partition_i     (partition_i),
    .block_number_i  (block_number_i),
    .byte_count_i    (byte_count_i),
    .retry_count_i   (retry_count_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_i        (status_o),
    .cylinder_word_i (cylinder_word_o),
    .track_i         (track_o),
    .sector_i        (sector_o),
    .word_count_i    (word_count_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Watchdog: a hang shows up as a long stretch with no transaction on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: per result, hold stall high or not at random, then take the
  // transaction. Every 96 results, the first 20 go through with no stall.
  initial begin
    int unsigned hold;
    out_stall_i = 1'b0;
    results_taken = 0;
    @(negedge clk_i);
    forever begin
      hold = (results_taken % 96 < 20) ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      results_taken++;
      @(negedge clk_i);
    end
  end

  // Called at a falling edge. Leaves valid high on return so that the next
  // request can follow back to back; drain_requests() drops it.
  task automatic push_request(input logic [2:0]  dt,
                              input logic [2:0]  pt,
                              input logic [23:0] bn,
                              input logic [15:0] bc,
                              input logic [4:0]  rc);
    int unsigned gap;
    // first 24 of every 128 requests go out with no gap
    gap = (requests_sent % 128 < 24) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    drive_type_i   <= dt;
    partition_i    <= pt;
    block_number_i <= bn;
    byte_count_i   <= bc;
    retry_count_i  <= rc;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Every request yields a result, so an empty expectation queue means the
  // pipeline is empty and the masks may be touched.
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Setup cycle, access cycle, then idle with psel low so back-to-back writes
  // never assign psel twice in the same step.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_masks(input logic [15:0] early, input logic [15:0] late,
                           input logic [15:0] plus, input logic [15:0] minus);
    write_reg(dbchs_pkg::REG_STROBE_EARLY, early);
    write_reg(dbchs_pkg::REG_STROBE_LATE, late);
    write_reg(dbchs_pkg::REG_OFFSET_PLUS, plus);
    write_reg(dbchs_pkg::REG_OFFSET_MINUS, minus);
    mask_settings++;
  endtask

  // Mostly requests that fit their partition (the only path that reaches the
  // cylinder/track/sector math), plus exact-end, near-end and wild blocks.
  task automatic push_random_request();
    logic [2:0]  dt;
    logic [2:0]  pt;
    logic [23:0] bn;
    logic [15:0] bc;
    logic [4:0]  rc;
    int unsigned size;
    int unsigned nblk;
    int unsigned hi;
    int unsigned pick;
    dt = ($urandom_range(0, 99) < 6) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
    pt = 3'($urandom_range(0, 7));
    size = (dt < 4) ? 32'(dbchs_pkg::PART_BLOCKS[dt[1:0]][pt]) : $urandom_range(0, 495520);
    bc = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 4096));
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      // fits: pick block so that block + sectors stays within the partition
      nblk = (32'(bc) + 511) >> 9;
      if (size == 0) begin
        bn = '0;
      end else begin
        if (nblk > size) begin
          bc = '0;
          nblk = 0;
        end
        hi = (nblk == 0) ? size - 1 : size - nblk;
        bn = 24'($urandom_range(0, hi));
      end
    end else if (pick < 80) begin
      bn = 24'(size);
    end else if (pick < 90) begin
      bn = 24'(size - $urandom_range(0, (size < 64) ? size : 64));
    end else begin
      bn = 24'($urandom);
    end
    rc = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, 19)) : 5'($urandom_range(20, 31));
    push_request(dt, pt, bn, bc, rc);
  endtask

  initial begin
    logic [15:0] early;
    logic [15:0] late;
    logic [15:0] plus;
    logic [15:0] minus;

    // every input known from time zero
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    drive_type_i   = '0;
    partition_i    = '0;
    block_number_i = '0;
    byte_count_i   = '0;
    retry_count_i  = '0;
    requests_sent  = 0;
    mask_settings  = 1;  // reset values count as the first setting

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- directed, masks at reset value ----
    push_request(3'd4, 3'd0, 24'd0, 16'd0, 5'd0);                // no drive
    push_request(3'd7, 3'd7, 24'hFFFFFF, 16'hFFFF, 5'd31);       // no drive, all ones
    push_request(3'd0, 3'd0, 24'd0, 16'd0, 5'd0);                // first block
    push_request(3'd0, 3'd7, 24'd495520, 16'd0, 5'd0);           // exactly at end
    push_request(3'd0, 3'd7, 24'd495519, 16'd512, 5'd0);         // last block, fits
    push_request(3'd0, 3'd7, 24'd495519, 16'd513, 5'd0);         // runs one past end
    push_request(3'd1, 3'd4, 24'd0, 16'd0, 5'd0);                // empty partition
    push_request(3'd1, 3'd5, 24'd1, 16'd0, 5'd0);                // beyond empty partition
    push_request(3'd2, 3'd2, 24'd0, 16'hFFFF, 5'd0);             // largest transfer
    push_request(3'd3, 3'd2, 24'd59179, 16'd1, 5'd0);
    // last sector of the first cylinder on every geometry
    push_request(3'd0, 3'd0, 24'd607, 16'd0, 5'd0);
    push_request(3'd1, 3'd1, 24'd417, 16'd2, 5'd0);
    push_request(3'd2, 3'd2, 24'd159, 16'd3, 5'd0);
    push_request(3'd3, 3'd1, 24'd109, 16'd4, 5'd0);
    push_request(3'd0, 3'd0, 24'hFFFFFF, 16'd0, 5'd0);           // block far out of range
    drain_requests();

    // ---- directed retry sweep, one distinct high bit per mask ----
    set_masks(16'h8000, 16'h4000, 16'h2000, 16'h1000);
    foreach (dbchs_pkg::RECOV_TABLE[i]) begin
      // one attempt per distinct recovery code, plus the tail of the table
      if (i == 0 || i == 3 || i == 5 || i == 7 || i == 9 || i == 11 || i == 13 || i == 19)
        push_request(3'd0, 3'd6, 24'd154431, 16'd2, 5'(i));
    end
    push_request(3'd0, 3'd6, 24'd154431, 16'd2, 5'd25);          // retry past table
    drain_requests();

    // ---- random phases, each under its own mask setting ----
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          early = 16'hFFFF; late = 16'hFFFF; plus = 16'hFFFF; minus = 16'hFFFF;
        end
        2: begin
          // low bits collide with real cylinder bits
          early = 16'h0001; late = 16'h0002; plus = 16'h0004; minus = 16'h0008;
        end
        4: begin
          early = 16'h0000; late = 16'h0000; plus = 16'h0000; minus = 16'h0000;
        end
        default: begin
          early = 16'($urandom); late = 16'($urandom);
          plus = 16'($urandom); minus = 16'($urandom);
        end
      endcase
      set_masks(early, late, plus, minus);
      repeat (ITEMS_PER_PHASE) push_random_request();
      drain_requests();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Run covered %0d requests and %0d results over %0d mask settings.",
             requests_sent, results_taken, mask_settings);
    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
